>>> hw/rtl/point_in_polygon_test_defines.svh
// ----------------------------------------------------------------------------
// point_in_polygon_test_defines
// assertion macros shared by the point-in-polygon block
// ----------------------------------------------------------------------------
`ifndef POINT_IN_POLYGON_TEST_DEFINES_SVH
`define POINT_IN_POLYGON_TEST_DEFINES_SVH

`ifndef SYNTH
// checked property, held off while reset is high
`define PIP_ASSERT(label, clk, rst, prop) \
   label: assert property (@(posedge clk) disable iff (rst) prop) \
      else $error("pip assertion failed");
// checked property, also during reset
`define PIP_ASSERT_ALWAYS(label, clk, prop) \
   label: assert property (@(posedge clk) prop) \
      else $error("pip assertion failed");
`else
`define PIP_ASSERT(label, clk, rst, prop)
`define PIP_ASSERT_ALWAYS(label, clk, prop)
`endif

`endif

>>> hw/rtl/pip_pkg.sv
// ----------------------------------------------------------------------------
// pip_pkg
// types and codes of the point-in-polygon crossing test
// ----------------------------------------------------------------------------
package pip_pkg;

   localparam int FIELD_BITS = 32;

   localparam logic [1:0] OP_APPEND = 2'd0;
   localparam logic [1:0] OP_QUERY  = 2'd1;
   localparam logic [1:0] OP_CLEAR  = 2'd2;

   typedef enum logic [1:0] {
      ST_IDLE,
      ST_WALK,
      ST_DONE
   } state_type;

   typedef struct packed {
      logic [1:0]                   op;
      logic signed [FIELD_BITS-1:0] coord_x;
      logic signed [FIELD_BITS-1:0] coord_y;
   } req_type;

   typedef struct packed {
      logic inside_res;
      logic on_boundary;
      logic overflow;
   } rsp_type;

   // walk control from the sequencer, aligned with the memory read data
   typedef struct packed {
      logic active;
      logic rd_valid;
      logic rd_last;
   } walk_ctl_type;

   // walk outcome back to the sequencer
   typedef struct packed {
      logic done;
      logic on_boundary;
      logic contained;
   } walk_res_type;

endpackage

>>> hw/rtl/pip_ram.sv
// ----------------------------------------------------------------------------
// pip_ram
// generic single write port, single read port ram with registered read
// ----------------------------------------------------------------------------
module pip_ram #(
   parameter int WIDTH = 64,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic                     rd_en,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/pip_crossing.sv
// ----------------------------------------------------------------------------
// pip_crossing
// edge pipeline: translate, form edge, exact products, signed crossing sum
// ----------------------------------------------------------------------------
module pip_crossing
   import pip_pkg::*;
#(
   parameter int COORD_BITS = 32,
   parameter int INC_BITS   = 13
) (
   input  logic                         clock,
   input  walk_ctl_type                 ctl,
   input  logic signed [COORD_BITS-1:0] vx,
   input  logic signed [COORD_BITS-1:0] vy,
   input  logic signed [COORD_BITS-1:0] px,
   input  logic signed [COORD_BITS-1:0] py,
   output walk_res_type                 res
);

   localparam int DB = COORD_BITS + 1;
   localparam int PB = 2 * DB;

   // translated vertex
   logic                 t_valid_ff, t_valid_in;
   logic                 t_last_ff, t_last_in;
   logic signed [DB-1:0] tx_ff, tx_in, ty_ff, ty_in;

   // edge forming
   logic                 have_first_ff, have_first_in;
   logic                 close_ff, close_in;
   logic signed [DB-1:0] first_x_ff, first_y_ff, prev_x_ff, prev_y_ff;

   // edge register
   logic                 e_valid_ff, e_valid_in;
   logic                 e_last_ff, e_last_in;
   logic signed [DB-1:0] exi_ff, eyi_ff, exj_ff, eyj_ff;
   logic signed [DB-1:0] exj_in;

   // product register
   logic                 p_valid_ff, p_valid_in;
   logic                 p_last_ff;
   logic                 qual_ff, gt_ff, lt_ff, ylez_ff, touch_ff;
   logic                 qual_in, gt_in, lt_in, ylez_in, touch_in;
   logic signed [PB-1:0] pa_ff, pb_ff, pa_in, pb_in;

   // accumulator
   logic signed [INC_BITS-1:0] inc_ff, inc_in, inc_next, step;
   logic                       bnd, prod_eq, prod_gt, prod_lt, xi0, xj0;

   assign tx_in      = {vx[COORD_BITS-1], vx} - {px[COORD_BITS-1], px};
   assign ty_in      = {vy[COORD_BITS-1], vy} - {py[COORD_BITS-1], py};
   assign t_valid_in = ctl.active && ctl.rd_valid;
   assign t_last_in  = ctl.active && ctl.rd_valid && ctl.rd_last;

   assign have_first_in = ctl.active && (have_first_ff || t_valid_ff);
   assign close_in      = ctl.active && t_valid_ff && t_last_ff;

   // start of each edge is always the previous vertex; the closing edge ends at the first
   assign e_valid_in = ctl.active && ((t_valid_ff && have_first_ff) || close_ff);
   assign e_last_in  = close_ff;
   assign exj_in     = close_ff ? first_x_ff : tx_ff;

   always_ff @(posedge clock) begin
      t_valid_ff    <= t_valid_in;
      t_last_ff     <= t_last_in;
      tx_ff         <= tx_in;
      ty_ff         <= ty_in;
      have_first_ff <= have_first_in;
      close_ff      <= close_in;
      if (t_valid_ff) begin
         prev_x_ff <= tx_ff;
         prev_y_ff <= ty_ff;
         if (!have_first_ff) begin
            first_x_ff <= tx_ff;
            first_y_ff <= ty_ff;
         end
      end
      e_valid_ff <= e_valid_in;
      e_last_ff  <= e_last_in;
      exi_ff     <= prev_x_ff;
      eyi_ff     <= prev_y_ff;
      exj_ff     <= exj_in;
      eyj_ff     <= close_ff ? first_y_ff : ty_ff;
   end

   assign xi0      = (exi_ff == '0);
   assign xj0      = (exj_ff == '0);
   assign qual_in  = (xi0 || xj0 || (exi_ff[DB-1] != exj_ff[DB-1]))
                     && (!eyi_ff[DB-1] || !eyj_ff[DB-1]);
   assign gt_in    = exi_ff > exj_ff;
   assign lt_in    = exi_ff < exj_ff;
   assign ylez_in  = eyi_ff[DB-1] || (eyi_ff == '0) || eyj_ff[DB-1] || (eyj_ff == '0);
   assign touch_in = xi0 || xj0;
   assign pa_in    = PB'(exi_ff) * PB'(eyj_ff);
   assign pb_in    = PB'(exj_ff) * PB'(eyi_ff);
   assign p_valid_in = ctl.active && e_valid_ff;

   always_ff @(posedge clock) begin
      p_valid_ff <= p_valid_in;
      p_last_ff  <= e_last_ff;
      qual_ff    <= qual_in;
      gt_ff      <= gt_in;
      lt_ff      <= lt_in;
      ylez_ff    <= ylez_in;
      touch_ff   <= touch_in;
      pa_ff      <= pa_in;
      pb_ff      <= pb_in;
   end

   assign prod_eq = (pa_ff == pb_ff);
   assign prod_gt = (pa_ff > pb_ff);
   assign prod_lt = (pa_ff < pb_ff);

   always_comb begin
      step = '0;
      if (qual_ff && gt_ff && prod_gt) begin
         step = touch_ff ? INC_BITS'(1) : INC_BITS'(2);
      end else if (qual_ff && lt_ff && prod_lt) begin
         step = touch_ff ? -INC_BITS'(1) : -INC_BITS'(2);
      end
   end

   assign bnd      = qual_ff && (((gt_ff || lt_ff) && prod_eq) || (!gt_ff && !lt_ff && ylez_ff));
   assign inc_next = inc_ff + step;
   assign inc_in   = !ctl.active ? '0 : (p_valid_ff ? inc_next : inc_ff);

   always_ff @(posedge clock) begin
      inc_ff <= inc_in;
   end

   assign res.done        = ctl.active && p_valid_ff && (bnd || p_last_ff);
   assign res.on_boundary = bnd;
   assign res.contained   = bnd || (inc_next == INC_BITS'(2));

endmodule

>>> hw/rtl/point_in_polygon_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test
// crossing-number point-in-polygon test over a stored contour
// ----------------------------------------------------------------------------
// Append and clear transfers give their response in the output register on
// the next cycle. During a query the vertex memory, which has one read port,
// is read one vertex a cycle by the walk, followed by the translate, edge,
// product and sum stages. A point found on an edge ends the walk early. A
// query on an empty contour answers at once. The vertex memory needs no
// clearing pass after reset; entries are read only below the vertex count.
`include "point_in_polygon_test_defines.svh"

module point_in_polygon_test
   import pip_pkg::*;
#(
   parameter int MAX_VERTICES = 1024,
   parameter int COORD_BITS   = 32
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_stall,
   output rsp_type rsp_data
);

   localparam int CNT_BITS  = $clog2(MAX_VERTICES + 1);
   localparam int ADDR_BITS = $clog2(MAX_VERTICES);
   localparam int INC_BITS  = CNT_BITS + 2;

   state_type state_ff, state_in;

   logic [CNT_BITS-1:0]  vertex_count_ff, vertex_count_in;
   logic [ADDR_BITS-1:0] rd_idx_ff, rd_idx_in;
   logic                 issuing_ff, issuing_in;
   logic                 rdv_ff, rdl_ff;
   logic signed [COORD_BITS-1:0] px_ff, py_ff;
   logic                 load_point;

   logic    rsp_valid_ff, rsp_valid_in, rsp_load;
   rsp_type rsp_data_ff, rsp_in;
   rsp_type res_ff, res_in;

   logic req_fire, out_free, wr_en, rd_en, rd_last;
   logic [2*COORD_BITS-1:0] wr_data, rd_data;

   walk_ctl_type ctl;
   walk_res_type walk_res;

   assign out_free  = !rsp_valid_ff || !rsp_stall;
   assign req_stall = (state_ff != ST_IDLE) || !out_free;
   assign req_fire  = req_valid && !req_stall;
   assign rd_last   = ({{(CNT_BITS-ADDR_BITS){1'b0}}, rd_idx_ff} == vertex_count_ff - 1'b1);
   assign wr_data   = {req_data.coord_x[COORD_BITS-1:0], req_data.coord_y[COORD_BITS-1:0]};

   always_comb begin
      state_in        = state_ff;
      vertex_count_in = vertex_count_ff;
      rd_idx_in       = rd_idx_ff;
      issuing_in      = issuing_ff;
      wr_en           = 1'b0;
      rd_en           = 1'b0;
      load_point      = 1'b0;
      rsp_load        = 1'b0;
      rsp_in          = '0;
      res_in          = res_ff;
      unique case (state_ff)
         ST_IDLE: begin
            if (req_fire) begin
               unique case (req_data.op)
                  OP_APPEND: begin
                     rsp_load = 1'b1;
                     if (vertex_count_ff < CNT_BITS'(MAX_VERTICES)) begin
                        wr_en           = 1'b1;
                        vertex_count_in = vertex_count_ff + 1'b1;
                     end else begin
                        rsp_in.overflow = 1'b1;
                     end
                  end
                  OP_QUERY: begin
                     if (vertex_count_ff == '0) begin
                        rsp_load = 1'b1;
                     end else begin
                        state_in   = ST_WALK;
                        rd_idx_in  = '0;
                        issuing_in = 1'b1;
                        load_point = 1'b1;
                     end
                  end
                  OP_CLEAR: begin
                     rsp_load        = 1'b1;
                     vertex_count_in = '0;
                  end
                  default: begin
                     rsp_load = 1'b1;
                  end
               endcase
            end
         end
         ST_WALK: begin
            if (issuing_ff) begin
               rd_en     = 1'b1;
               rd_idx_in = rd_idx_ff + 1'b1;
               if (rd_last) begin
                  issuing_in = 1'b0;
               end
            end
            if (walk_res.done) begin
               state_in           = ST_DONE;
               issuing_in         = 1'b0;
               res_in.inside_res  = walk_res.contained;
               res_in.on_boundary = walk_res.on_boundary;
               res_in.overflow    = 1'b0;
            end
         end
         ST_DONE: begin
            if (out_free) begin
               rsp_load = 1'b1;
               rsp_in   = res_ff;
               state_in = ST_IDLE;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff        <= ST_IDLE;
         vertex_count_ff <= '0;
         issuing_ff      <= 1'b0;
         rsp_valid_ff    <= 1'b0;
         rdv_ff          <= 1'b0;
      end else begin
         state_ff        <= state_in;
         vertex_count_ff <= vertex_count_in;
         issuing_ff      <= issuing_in;
         rsp_valid_ff    <= rsp_valid_in;
         rdv_ff          <= rd_en;
      end
   end

   always_ff @(posedge clock) begin
      rd_idx_ff <= rd_idx_in;
      rdl_ff    <= rd_en && rd_last;
      res_ff    <= res_in;
      if (rsp_load) begin
         rsp_data_ff <= rsp_in;
      end
      if (load_point) begin
         px_ff <= req_data.coord_x[COORD_BITS-1:0];
         py_ff <= req_data.coord_y[COORD_BITS-1:0];
      end
   end

   pip_ram #(
      .WIDTH (2 * COORD_BITS),
      .DEPTH (MAX_VERTICES)
   ) u_vertex_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (vertex_count_ff[ADDR_BITS-1:0]),
      .wr_data (wr_data),
      .rd_en   (rd_en),
      .rd_addr (rd_idx_ff),
      .rd_data (rd_data)
   );

   assign ctl.active   = (state_ff == ST_WALK);
   assign ctl.rd_valid = rdv_ff;
   assign ctl.rd_last  = rdl_ff;

   pip_crossing #(
      .COORD_BITS (COORD_BITS),
      .INC_BITS   (INC_BITS)
   ) u_crossing (
      .clock (clock),
      .ctl   (ctl),
      .vx    (rd_data[2*COORD_BITS-1:COORD_BITS]),
      .vy    (rd_data[COORD_BITS-1:0]),
      .px    (px_ff),
      .py    (py_ff),
      .res   (walk_res)
   );

   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_data_ff;

   // store never holds more than its capacity
   `PIP_ASSERT(a_count_bound, clock, reset, vertex_count_ff <= CNT_BITS'(MAX_VERTICES))
   // walk reads stay below the vertex count
   `PIP_ASSERT(a_rd_in_range, clock, reset, rd_en |-> (CNT_BITS'(rd_idx_ff) < vertex_count_ff))
   // a walk outcome only appears while walking
   `PIP_ASSERT(a_done_in_walk, clock, reset, walk_res.done |-> state_ff == ST_WALK)
   // a boundary point always reports as inside
   `PIP_ASSERT(a_bnd_flags, clock, reset, rsp_valid_ff |-> (!rsp_data_ff.on_boundary || rsp_data_ff.inside_res))
   // an overflow never reports as inside
   `PIP_ASSERT(a_ovf_flags, clock, reset, rsp_valid_ff |-> !(rsp_data_ff.overflow && rsp_data_ff.inside_res))
   // vertex store written only from idle
   `PIP_ASSERT_ALWAYS(a_write_idle, clock, wr_en |-> state_ff == ST_IDLE)

endmodule

>>> tb/point_in_polygon_test_test.sv
// ----------------------------------------------------------------------------
// point_in_polygon_test_test
// self-checking bench for the point-in-polygon crossing test
// ----------------------------------------------------------------------------
// Items are queued up front and driven one transfer at a time. A shadow copy
// of the vertex store predicts each response on acceptance: exact 34-bit edge
// offsets, 68-bit cross products and the signed crossing sum. Responses are
// checked in order against the predictions. Both sides idle in random bursts.
// ----------------------------------------------------------------------------
`timescale 1ns / 100ps

module point_in_polygon_test_test;
   import pip_pkg::*;

   localparam int MAX_VERTS  = 1024;
   localparam int QUIET_TAIL = 60;
   localparam logic [1:0] OP_UNUSED = 2'd3;
   localparam logic signed [31:0] COORD_MIN = 32'sh8000_0000;
   localparam logic signed [31:0] COORD_MAX = 32'sh7fff_ffff;

   typedef enum logic [1:0] {
      PT_OUTSIDE,
      PT_INSIDE,
      PT_ON_EDGE
   } point_class_type;

   logic    clock = 1'b0;
   logic    reset = 1'b1;
   logic    req_valid = 1'b0;
   logic    req_stall;
   req_type req_data = '0;
   logic    rsp_valid;
   logic    rsp_stall = 1'b0;
   rsp_type rsp_data;

   req_type req_backlog[$];
   rsp_type awaited_rsp[$];
   rsp_type head_rsp;
   int      mismatch_count = 0;
   int      src_gap = 0;
   int      src_lull = 0;
   int      snk_gap = 0;
   int      snk_lull = 0;

   // shadow of the contour held by the block
   logic signed [31:0] shadow_x [MAX_VERTS];
   logic signed [31:0] shadow_y [MAX_VERTS];
   int                 shadow_count = 0;

   point_in_polygon_test #(
      .MAX_VERTICES(MAX_VERTS),
      .COORD_BITS  (32)
   ) dut (
      .clock    (clock),
      .reset    (reset),
      .req_valid(req_valid),
      .req_stall(req_stall),
      .req_data (req_data),
      .rsp_valid(rsp_valid),
      .rsp_stall(rsp_stall),
      .rsp_data (rsp_data)
   );

   always begin
      #4 clock = 1'b1;
      #4 clock = 1'b0;
   end

   function automatic point_class_type classify_point(input logic signed [31:0] px,
                                                      input logic signed [31:0] py);
      int                 crossing_sum;
      int                 k, m;
      logic signed [33:0] vx, vy, wx, wy, qx, qy;
      logic signed [33:0] xi, yi, xj, yj;
      logic signed [67:0] lhs, rhs;
      logic               straddle, touch;
      crossing_sum = 0;
      qx = 34'(px);
      qy = 34'(py);
      for (k = 0; k < shadow_count; k++) begin
         m = (k + 1 == shadow_count) ? 0 : k + 1;
         vx = 34'(shadow_x[k]);
         vy = 34'(shadow_y[k]);
         wx = 34'(shadow_x[m]);
         wy = 34'(shadow_y[m]);
         xi = vx - qx;
         yi = vy - qy;
         xj = wx - qx;
         yj = wy - qy;
         straddle = (xi == 0) || (xj == 0) || ((xi < 0) != (xj < 0));
         touch = (xi == 0) || (xj == 0);
         if (straddle && ((yi >= 0) || (yj >= 0))) begin
            lhs = 68'(xi) * 68'(yj);
            rhs = 68'(xj) * 68'(yi);
            if (xi > xj) begin
               if (lhs > rhs) crossing_sum += touch ? 1 : 2;
               else if (lhs == rhs) return PT_ON_EDGE;
            end else if (xi < xj) begin
               if (lhs < rhs) crossing_sum -= touch ? 1 : 2;
               else if (lhs == rhs) return PT_ON_EDGE;
            end else if ((yi <= 0) || (yj <= 0)) begin
               // vertical edge through the point
               return PT_ON_EDGE;
            end
         end
      end
      return (crossing_sum == 2) ? PT_INSIDE : PT_OUTSIDE;
   endfunction

   function automatic rsp_type contour_response(input req_type item);
      rsp_type         r;
      point_class_type where;
      r = '0;
      case (item.op)
         OP_APPEND: begin
            if (shadow_count < MAX_VERTS) begin
               shadow_x[shadow_count] = item.coord_x;
               shadow_y[shadow_count] = item.coord_y;
               shadow_count++;
            end else begin
               r.overflow = 1'b1;
            end
         end
         OP_QUERY: begin
            where = classify_point(item.coord_x, item.coord_y);
            r.inside_res  = (where != PT_OUTSIDE);
            r.on_boundary = (where == PT_ON_EDGE);
         end
         OP_CLEAR: begin
            shadow_count = 0;
         end
         default: ;
      endcase
      return r;
   endfunction

   task automatic queue_item(input logic [1:0] op, input longint x, input longint y);
      req_type item;
      item.op      = op;
      item.coord_x = x[31:0];
      item.coord_y = y[31:0];
      req_backlog = {req_backlog, item};
   endtask

   // request side: predict on acceptance, then present the next item or idle
   always @(posedge clock) begin
      if (reset) begin
         req_valid <= 1'b0;
         req_data  <= '0;
      end else begin
         if (req_valid && !req_stall) begin
            awaited_rsp = {awaited_rsp, contour_response(req_data)};
         end
         if (req_valid && req_stall) begin
            // stalled payload stays put
         end else if (src_gap > 0) begin
            src_gap--;
            req_valid <= 1'b0;
         end else if (req_backlog.size() == 0) begin
            req_valid <= 1'b0;
         end else if (req_backlog.size() > QUIET_TAIL && src_lull == 0
                      && $urandom_range(0, 4) == 0) begin
            src_gap  = $urandom_range(0, 16);
            src_lull = $urandom_range(0, 60);
            req_valid <= 1'b0;
         end else begin
            if (src_lull > 0) src_lull--;
            req_valid <= 1'b1;
            req_data  <= req_backlog.pop_front();
         end
      end
   end

   // response side: check each transfer, then decide on stall for the next cycle
   always @(posedge clock) begin
      if (reset) begin
         rsp_stall <= 1'b0;
      end else begin
         if (rsp_valid && !rsp_stall) begin
            if (awaited_rsp.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= 10)
                  $display("unexpected response: inside %b boundary %b overflow %b",
                           rsp_data.inside_res, rsp_data.on_boundary, rsp_data.overflow);
            end else begin
               head_rsp = awaited_rsp.pop_front();
               if (rsp_data.inside_res !== head_rsp.inside_res
                   || rsp_data.on_boundary !== head_rsp.on_boundary
                   || rsp_data.overflow !== head_rsp.overflow) begin
                  mismatch_count++;
                  if (mismatch_count <= 10)
                     $display({"mismatch at %0t: expected inside %b boundary %b ",
                               "overflow %b, got %b %b %b"},
                              $realtime, head_rsp.inside_res, head_rsp.on_boundary,
                              head_rsp.overflow, rsp_data.inside_res,
                              rsp_data.on_boundary, rsp_data.overflow);
               end
            end
         end
         if (snk_gap > 0) begin
            snk_gap--;
            rsp_stall <= 1'b1;
         end else if (req_backlog.size() > QUIET_TAIL && snk_lull == 0
                      && $urandom_range(0, 4) == 0) begin
            snk_gap  = $urandom_range(0, 16);
            snk_lull = $urandom_range(0, 60);
            rsp_stall <= 1'b1;
         end else begin
            if (snk_lull > 0) snk_lull--;
            rsp_stall <= 1'b0;
         end
      end
   end

   initial begin
      longint org_x, org_y, step, side, qx, qy;
      longint gx[$], gy[$];
      int     n, nq, i, j, a, b, pick, random_items;
      logic [1:0] op;

      // short directed run: empty contour, one and two vertices, extremes
      queue_item(OP_QUERY, 0, 0);
      queue_item(OP_APPEND, 5, 7);
      queue_item(OP_QUERY, 5, 7);
      queue_item(OP_QUERY, 6, 7);
      queue_item(OP_APPEND, 9, 9);
      queue_item(OP_QUERY, 7, 8);
      queue_item(OP_QUERY, 7, 9);
      queue_item(OP_CLEAR, 0, 0);
      queue_item(OP_APPEND, COORD_MIN, COORD_MIN);
      queue_item(OP_APPEND, COORD_MIN, COORD_MAX);
      queue_item(OP_APPEND, COORD_MAX, COORD_MAX);
      queue_item(OP_APPEND, COORD_MAX, COORD_MIN);
      queue_item(OP_QUERY, 0, 0);
      queue_item(OP_QUERY, COORD_MAX, 0);
      queue_item(OP_QUERY, COORD_MIN, COORD_MIN);
      queue_item(OP_QUERY, -1, -1);
      queue_item(OP_CLEAR, 0, 0);
      // anticlockwise triangle: a point inside it counts as contained
      queue_item(OP_APPEND, 0, 0);
      queue_item(OP_APPEND, 'h10000, 0);
      queue_item(OP_APPEND, 0, 'h10000);
      queue_item(OP_QUERY, 'h100, 'h100);
      queue_item(OP_UNUSED, -1, -1);
      queue_item(OP_QUERY, 'h100, 0);
      queue_item(OP_CLEAR, -1, -1);

      // larger clockwise square outline
      step = 64'sd65536;
      side = 20 * step;
      for (i = 0; i < 40; i++) queue_item(OP_APPEND, -side, -side + i * step);
      for (i = 0; i < 40; i++) queue_item(OP_APPEND, -side + i * step, side);
      for (i = 0; i < 40; i++) queue_item(OP_APPEND, side, side - i * step);
      for (i = 0; i < 40; i++) queue_item(OP_APPEND, side - i * step, -side);
      queue_item(OP_QUERY, 0, 0);
      queue_item(OP_QUERY, side, 5);
      queue_item(OP_QUERY, side + 1, 0);
      queue_item(OP_CLEAR, 0, 0);

      // random part: mostly small contours with probing queries, some noise
      random_items = 0;
      while (random_items < 260) begin
         if ($urandom_range(0, 4) != 0) begin
            case ($urandom_range(0, 3))
               0: step = 1;
               1: step = 65536;
               default: step = $urandom_range(1, 1 << 20);
            endcase
            org_x = longint'($urandom_range(0, 32'h7fff_ffff)) - (64'sd1 <<< 30);
            org_y = longint'($urandom_range(0, 32'h7fff_ffff)) - (64'sd1 <<< 30);
            // now and then push the contour against the coordinate limits
            if ($urandom_range(0, 7) == 0) org_x = 64'sd2147483647 - 14 * step;
            if ($urandom_range(0, 7) == 0) org_y = -64'sd2147483648 + 14 * step;
            pick = $urandom_range(0, 19);
            case (pick)
               0: n = 0;
               1: n = 1;
               2: n = 2;
               3: n = $urandom_range(13, 40);
               default: n = $urandom_range(3, 12);
            endcase
            gx.delete();
            gy.delete();
            queue_item(OP_CLEAR, 0, 0);
            for (i = 0; i < n; i++) begin
               gx = {gx, org_x + 2 * step * (int'($urandom_range(0, 12)) - 6)};
               gy = {gy, org_y + 2 * step * (int'($urandom_range(0, 12)) - 6)};
               queue_item(OP_APPEND, gx[i], gy[i]);
            end
            nq = $urandom_range(2, 6);
            for (j = 0; j < nq; j++) begin
               pick = $urandom_range(0, 9);
               qx = org_x + step * (int'($urandom_range(0, 28)) - 14);
               qy = org_y + step * (int'($urandom_range(0, 28)) - 14);
               if (n > 0 && pick >= 4) begin
                  a = $urandom_range(0, n - 1);
                  b = (a + 1 == n) ? 0 : a + 1;
                  if (pick < 6) begin
                     qx = gx[a];
                     qy = gy[a];
                  end else if (pick < 8) begin
                     // edge midpoint, exact on the even grid
                     qx = (gx[a] + gx[b]) / 2;
                     qy = (gy[a] + gy[b]) / 2;
                  end else begin
                     qx = gx[a];
                  end
               end
               queue_item(OP_QUERY, qx, qy);
            end
            random_items += n + nq + 1;
         end else begin
            op = 2'($urandom_range(0, 3));
            queue_item(op, longint'($urandom), longint'($urandom));
            if (op != OP_UNUSED) random_items++;
         end
      end

      repeat (8) @(posedge clock);
      reset <= 1'b0;

      while (req_backlog.size() != 0 || req_valid) @(posedge clock);
      while (awaited_rsp.size() != 0) @(posedge clock);
      repeat (40) @(posedge clock);
      if (mismatch_count == 0)
         $display("TB_OK");
      else
         $display("TB_ERROR");
      $finish;
   end

   initial begin
      #4_000_000;
      $display("TB_ERROR");
      $finish;
   end

endmodule
